// ===== design/assert_macros.svh =====
// assertion macros shared by the radix-3 butterfly rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle (consequent may start with a delay)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/d3q_pkg.sv =====
// types, constants and rounding helper for the radix-3 butterfly
// no dependencies
package d3q_pkg;

	typedef logic signed [31:0] q31_t;

	typedef struct packed {
		q31_t re;
		q31_t im;
	} cplx_t;

	// 1/3 in q1.31
	localparam q31_t SCALE_Q31 = 32'sd715827883;
	// sqrt(3)/2 in q1.31
	localparam q31_t TWID_IM_Q31 = 32'sd1859775393;
	// real part of both twiddles is -0.5, i.e. -2^30 in q1.31
	localparam int unsigned TWID_RE_SHIFT = 30;

	localparam q31_t Q31_MAX = 32'sh7fffffff;
	localparam q31_t Q31_MIN = 32'sh80000000;

	// shift right by 31 with rounding half away from zero
	function automatic q31_t round_q31(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + (v[63] ? 64'sd1073741823 : 64'sd1073741824);
		return t[62:31];
	endfunction

endpackage

// ===== design/d3q_scale_lane.sv =====
// one prescale lane: component times 1/3, rounded to q1.31
// depends on d3q_pkg
module d3q_scale_lane (
	input  logic            clk,
	input  d3q_pkg::q31_t   x,
	output d3q_pkg::q31_t   s
);

	logic signed [62:0] prod_s1;
	d3q_pkg::q31_t      s_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= 63'(x) * 63'(d3q_pkg::SCALE_Q31);
		// magnitude stays below 2^30, no saturation needed
		s_s2    <= d3q_pkg::round_q31(64'(prod_s1));
	end

	assign s = s_s2;

endmodule

// ===== design/d3q_twiddle_lane.sv =====
// one twiddle lane: -(a+b)/2 +/- (sqrt(3)/2)(c-d), both bins at once
// depends on d3q_pkg
module d3q_twiddle_lane (
	input  logic            clk,
	input  d3q_pkg::q31_t   sum_a,
	input  d3q_pkg::q31_t   sum_b,
	input  d3q_pkg::q31_t   dif_a,
	input  d3q_pkg::q31_t   dif_b,
	output d3q_pkg::q31_t   r_pos,
	output d3q_pkg::q31_t   r_neg
);

	logic signed [32:0] dif;
	logic signed [32:0] sum_s3;
	logic signed [63:0] prod_s3;
	logic signed [63:0] base;
	logic signed [63:0] w_pos_s4;
	logic signed [63:0] w_neg_s4;
	d3q_pkg::q31_t      r_pos_s5;
	d3q_pkg::q31_t      r_neg_s5;

	assign dif  = 33'(dif_a) - 33'(dif_b);
	assign base = -(64'(sum_s3) <<< d3q_pkg::TWID_RE_SHIFT);

	always_ff @(posedge clk) begin
		sum_s3   <= 33'(sum_a) + 33'(sum_b);
		prod_s3  <= 64'(dif) * 64'(d3q_pkg::TWID_IM_Q31);
		// exact q2.62 sums, half scale; never near the 64-bit limits
		w_pos_s4 <= base + prod_s3;
		w_neg_s4 <= base - prod_s3;
		r_pos_s5 <= d3q_pkg::round_q31(w_pos_s4);
		r_neg_s5 <= d3q_pkg::round_q31(w_neg_s4);
	end

	assign r_pos = r_pos_s5;
	assign r_neg = r_neg_s5;

endmodule

// ===== design/d3q_merge.sv =====
// merging stage: saturating adds of scaled x0 onto the lane results; bin 0 sums are only saturated
// depends on d3q_pkg and assert_macros.svh
`include "assert_macros.svh"

module d3q_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vld,
	input  d3q_pkg::cplx_t      x0,
	input  logic signed [33:0]  sum0_re,
	input  logic signed [33:0]  sum0_im,
	input  d3q_pkg::cplx_t      r1,
	input  d3q_pkg::cplx_t      r2,
	output logic                done,
	output d3q_pkg::cplx_t      y0,
	output d3q_pkg::cplx_t      y1,
	output d3q_pkg::cplx_t      y2
);

	function automatic d3q_pkg::q31_t sat34(input logic signed [33:0] v);
		if (v > 34'(d3q_pkg::Q31_MAX)) begin
			return d3q_pkg::Q31_MAX;
		end else if (v < 34'(d3q_pkg::Q31_MIN)) begin
			return d3q_pkg::Q31_MIN;
		end
		return v[31:0];
	endfunction

	logic           done_q;
	d3q_pkg::cplx_t y0_q;
	d3q_pkg::cplx_t y1_q;
	d3q_pkg::cplx_t y2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		y0_q.re <= sat34(sum0_re);
		y0_q.im <= sat34(sum0_im);
		y1_q.re <= sat34(34'(x0.re) + 34'(r1.re));
		y1_q.im <= sat34(34'(x0.im) + 34'(r1.im));
		y2_q.re <= sat34(34'(x0.re) + 34'(r2.re));
		y2_q.im <= sat34(34'(x0.im) + 34'(r2.im));
	end

	assign done = done_q;
	assign y0   = y0_q;
	assign y1   = y1_q;
	assign y2   = y2_q;

	// twiddle part alone never reaches -1, so a low clip needs a negative x0
	`ASSERT_IMPL(a_y1_low_clip, clk, arst_n, done_q && (y1_q.re == d3q_pkg::Q31_MIN), $past(x0.re[31]), "y1_re clipped low with non-negative x0")
	`ASSERT_IMPL(a_y2_low_clip, clk, arst_n, done_q && (y2_q.im == d3q_pkg::Q31_MIN), $past(x0.im[31]), "y2_im clipped low with non-negative x0")

endmodule

// ===== design/dft3_q31_butterfly_core.sv =====
// radix-3 dft butterfly on complex q1.31 samples, output scaled by 1/3
// done: strobe registered together with the outputs, after stages s1 to s6
// throughput: one request per cycle, busy is never raised
// reset: arst_n clears the valid pipeline only, data registers are not reset
// depends on d3q_pkg, d3q_scale_lane, d3q_twiddle_lane, d3q_merge, assert_macros.svh
`include "assert_macros.svh"

module dft3_q31_butterfly_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   x0_re,
	input  logic signed [31:0]   x0_im,
	input  logic signed [31:0]   x1_re,
	input  logic signed [31:0]   x1_im,
	input  logic signed [31:0]   x2_re,
	input  logic signed [31:0]   x2_im,
	output logic                 done,
	output logic signed [31:0]   y0_re,
	output logic signed [31:0]   y0_im,
	output logic signed [31:0]   y1_re,
	output logic signed [31:0]   y1_im,
	output logic signed [31:0]   y2_re,
	output logic signed [31:0]   y2_im
);

	// pipeline map
	//   s1: six prescale multipliers (one per input component)
	//   s2: rounding of the prescale products to q1.31
	//   s3: twiddle lanes form x1+x2 and (sqrt3/2)*(x1-x2); bin 0 sums formed here
	//   s4: twiddle lanes combine the real -0.5 part with the +/- imaginary part
	//   s5: twiddle lanes round back to q1.31
	//   s6: merge adds scaled x0 with saturation, output registers

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic vld_s5;

	// fully pipelined, nothing ever blocks a request
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// prescale lanes: each component times 1/3, rounded half away from zero
	d3q_pkg::cplx_t sc0;
	d3q_pkg::cplx_t sc1;
	d3q_pkg::cplx_t sc2;

	d3q_scale_lane u_sc0_re (.clk(clk), .x(x0_re), .s(sc0.re));
	d3q_scale_lane u_sc0_im (.clk(clk), .x(x0_im), .s(sc0.im));
	d3q_scale_lane u_sc1_re (.clk(clk), .x(x1_re), .s(sc1.re));
	d3q_scale_lane u_sc1_im (.clk(clk), .x(x1_im), .s(sc1.im));
	d3q_scale_lane u_sc2_re (.clk(clk), .x(x2_re), .s(sc2.re));
	d3q_scale_lane u_sc2_im (.clk(clk), .x(x2_im), .s(sc2.im));

	// twiddle lanes
	// real lane: re = -(x1r+x2r)/2 +/- (sqrt3/2)(x1i-x2i); plus for bin 1, minus for bin 2
	// imag lane: im = -(x1i+x2i)/2 +/- (sqrt3/2)(x2r-x1r); plus for bin 1, minus for bin 2
	d3q_pkg::cplx_t r1;
	d3q_pkg::cplx_t r2;

	d3q_twiddle_lane u_tw_re (
		.clk   (clk),
		.sum_a (sc1.re),
		.sum_b (sc2.re),
		.dif_a (sc1.im),
		.dif_b (sc2.im),
		.r_pos (r1.re),
		.r_neg (r2.re)
	);

	d3q_twiddle_lane u_tw_im (
		.clk   (clk),
		.sum_a (sc1.im),
		.sum_b (sc2.im),
		.dif_a (sc2.re),
		.dif_b (sc1.re),
		.r_pos (r1.im),
		.r_neg (r2.im)
	);

	// bin 0 sums and scaled x0 ride along with the twiddle lanes
	// (a partial sum of two scaled values cannot clip, so one wide sum suffices)
	logic signed [33:0] sum0_re_s3;
	logic signed [33:0] sum0_im_s3;
	logic signed [33:0] sum0_re_s4;
	logic signed [33:0] sum0_im_s4;
	logic signed [33:0] sum0_re_s5;
	logic signed [33:0] sum0_im_s5;
	d3q_pkg::cplx_t     x0_s3;
	d3q_pkg::cplx_t     x0_s4;
	d3q_pkg::cplx_t     x0_s5;

	always_ff @(posedge clk) begin
		sum0_re_s3 <= 34'(sc0.re) + 34'(sc1.re) + 34'(sc2.re);
		sum0_im_s3 <= 34'(sc0.im) + 34'(sc1.im) + 34'(sc2.im);
		sum0_re_s4 <= sum0_re_s3;
		sum0_im_s4 <= sum0_im_s3;
		sum0_re_s5 <= sum0_re_s4;
		sum0_im_s5 <= sum0_im_s4;
		x0_s3      <= sc0;
		x0_s4      <= x0_s3;
		x0_s5      <= x0_s4;
	end

	// merging stage, registered outputs
	d3q_pkg::cplx_t y0;
	d3q_pkg::cplx_t y1;
	d3q_pkg::cplx_t y2;

	d3q_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_s5),
		.x0      (x0_s5),
		.sum0_re (sum0_re_s5),
		.sum0_im (sum0_im_s5),
		.r1      (r1),
		.r2      (r2),
		.done    (done),
		.y0      (y0),
		.y1      (y1),
		.y2      (y2)
	);

	assign y0_re = y0.re;
	assign y0_im = y0.im;
	assign y1_re = y1.re;
	assign y1_im = y1.im;
	assign y2_re = y2.re;
	assign y2_im = y2.im;

	// every accepted request produces a done strobe, and no done strobe comes without a request
	`ASSERT_IMPL(a_req_to_done, clk, arst_n, start && !busy, ##6 done, "accepted request produced no done strobe")
	`ASSERT_IMPL(a_done_from_req, clk, arst_n, done, $past(start, 6), "done strobe without a request")

endmodule
